[hw/rtl/pfde_pkg.sv]
// Shared types and constants of the plane fit distance error block.
package pfde_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int COUNT_BITS = 16;
  localparam int DIST_BITS  = COORD_BITS + FRAC_BITS + 1;
  localparam int ACC_BITS   = DIST_BITS + COUNT_BITS;

  // Plane math widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int NORM_W = 2 * DIFF_W + 1;
  localparam int OFF_W  = NORM_W + COORD_BITS + 2;
  localparam int LEN_W  = NORM_W + 1;
  localparam int MAG_W  = OFF_W + 1;
  localparam int NUM_W  = MAG_W + FRAC_BITS;
  localparam int RAD_W  = 2 * NORM_W;
  localparam int SUM_W  = RAD_W + 2;

  // Shared multiplier operands
  localparam int SQ_SPLIT = (NORM_W - 1) / 2;
  localparam int MA_W     = NORM_W + 1;
  localparam int MB_W     = DIFF_W + 1;
  localparam int PROD_W   = MA_W + MB_W;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [ACC_BITS-1:0]  ACC_MAX  = {ACC_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {
    REQ_REFERENCE = 1'b0,
    REQ_SAMPLE    = 1'b1
  } req_type_e;

  typedef enum logic {
    CMD_FIT    = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         coord_valid;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]  error_distance;
    logic [COUNT_BITS-1:0] point_count;
    logic                  no_points;
    logic                  degenerate_plane;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  // Work handed from the front to the engine. For a fit, pa/pb/pc are the
  // three reference points; for a sample only pc is used.
  typedef struct packed {
    cmd_kind_e kind;
    point_t    pa;
    point_t    pb;
    point_t    pc;
    logic      coord_valid;
    logic      last;
  } cmd_t;

endpackage

[hw/rtl/pfde_front.sv]
// Input front: reference point store, item classification and command queue.
module pfde_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  pfde_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output pfde_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);
  import pfde_pkg::*;

  point_t     ref_q [2];
  logic [1:0] ref_cnt_q, ref_cnt_d;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  point_t pt;
  logic   accept, enq, deq;
  cmd_t   cmd_new;

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign deq         = cmd_pop_i && cmd_valid_o;

  assign pt = '{x: in_item_i.x, y: in_item_i.y, z: in_item_i.z};

  always_comb begin
    enq       = 1'b0;
    ref_cnt_d = ref_cnt_q;
    cmd_new   = '{kind: CMD_SAMPLE, pa: ref_q[0], pb: ref_q[1], pc: pt,
                  coord_valid: in_item_i.coord_valid, last: in_item_i.last};
    if (accept) begin
      if (in_item_i.req_type == REQ_REFERENCE) begin
        if (in_item_i.coord_valid) begin
          if (ref_cnt_q == 2'd2) begin
            cmd_new.kind = CMD_FIT;
            enq          = 1'b1;
            ref_cnt_d    = 2'd0;
          end else begin
            ref_cnt_d = ref_cnt_q + 2'd1;
          end
        end
      end else begin
        // NaN samples that do not close a cloud have no effect
        enq = in_item_i.coord_valid || in_item_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cnt_q <= 2'd0;
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      ref_cnt_q <= ref_cnt_d;
      if (enq) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.req_type == REQ_REFERENCE && in_item_i.coord_valid
        && ref_cnt_q != 2'd2) begin
      ref_q[ref_cnt_q[0]] <= pt;
    end
    if (enq) mem_q[wr_q] <= cmd_new;
  end

endmodule

[hw/rtl/pfde_divider.sv]
// Radix-2 restoring divider with a quotient saturated to the distance width.
module pfde_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pfde_pkg::NUM_W-1:0]     num_i,
  input  logic [pfde_pkg::LEN_W-1:0]     den_i,
  output logic                           done_o,
  output logic [pfde_pkg::DIST_BITS-1:0] quot_o
);
  import pfde_pkg::*;

  localparam int CNT_W = $clog2(DIST_BITS);

  typedef enum logic [2:0] {
    DV_IDLE  = 3'b001,
    DV_CHECK = 3'b010,
    DV_RUN   = 3'b100
  } div_state_e;

  div_state_e           st_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [NUM_W-1:0]     num_q;
  logic [LEN_W-1:0]     den_q;
  logic [LEN_W-1:0]     rem_q;
  logic [DIST_BITS-1:0] low_q;

  logic [LEN_W:0] trial, trial_sub;
  logic           ge, sat;

  assign sat       = num_q[NUM_W-1:DIST_BITS] >= {1'b0, den_q};
  assign trial     = {rem_q, low_q[DIST_BITS-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  assign done_o = done_q;
  assign quot_o = low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        DV_IDLE: begin
          if (start_i) st_q <= DV_CHECK;
        end
        DV_CHECK: begin
          cnt_q <= '0;
          if (sat) begin
            done_q <= 1'b1;
            st_q   <= DV_IDLE;
          end else begin
            st_q <= DV_RUN;
          end
        end
        DV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIST_BITS - 1)) begin
            done_q <= 1'b1;
            st_q   <= DV_IDLE;
          end
        end
        default: st_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      DV_IDLE: begin
        if (start_i) begin
          num_q <= num_i;
          den_q <= den_i;
        end
      end
      DV_CHECK: begin
        // when not saturated, the upper part is below the divisor, so it fits the remainder
        rem_q <= num_q[NUM_W-2:DIST_BITS];
        low_q <= sat ? DIST_MAX : num_q[DIST_BITS-1:0];
      end
      DV_RUN: begin
        rem_q <= ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
        low_q <= {low_q[DIST_BITS-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/pfde_engine.sv]
// Back-end engine: plane fit sequencer, square root, distance and result queue.
module pfde_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               cmd_valid_i,
  input  pfde_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output pfde_pkg::out_item_t result_o
);
  import pfde_pkg::*;

  localparam int STEP_W     = 5;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int RCNT_W     = $clog2(ROOT_STEPS);
  localparam int REM_W      = LEN_W;

  // Microprogram steps: cross product, offset, squared norm, then sample dot
  localparam logic [STEP_W-1:0] STEP_FIT_FIRST = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SQ_LAST   = 5'd14;
  localparam logic [STEP_W-1:0] STEP_SMP_FIRST = 5'd15;
  localparam logic [STEP_W-1:0] STEP_SMP_LAST  = 5'd17;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_ACC   = 9'b000000100,
    ST_ROOT  = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_DWAIT = 9'b000100000,
    ST_UPD   = 9'b001000000,
    ST_RES   = 9'b010000000,
    ST_RWAIT = 9'b100000000
  } eng_state_e;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_NEG     = 3'd3,
    OP_ADD_OFF = 3'd4
  } acc_op_e;

  eng_state_e st_q;
  logic       emit_q;
  logic [STEP_W-1:0] step_q;
  logic [RCNT_W-1:0] rcnt_q;
  logic       mode_q;

  logic signed [NORM_W-1:0] n_q [3];
  logic signed [OFF_W-1:0]  off_q;
  logic [LEN_W-1:0]         len_q;
  logic [ACC_BITS-1:0]      err_q;
  logic [COUNT_BITS-1:0]    cnt_q;

  logic signed [DIFF_W-1:0] u_q [3];
  logic signed [DIFF_W-1:0] v_q [3];
  point_t                   pt_q;
  logic                     last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic [RAD_W-1:0]         rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [LEN_W-1:0]         root_q;
  logic [DIST_BITS-1:0]     dist_q;
  logic [DIST_BITS-1:0]     res_q;

  out_item_t  fifo_q [2];
  logic       fwr_q, frd_q;
  logic [1:0] fcnt_q;

  logic [NORM_W-2:0]        nmag [3];
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  acc_op_e                  op;
  logic                     shift_sq;
  logic signed [SUM_W-1:0]  term, acc_d;
  logic [MAG_W-1:0]         acc_mag;
  logic [REM_W+1:0]         rem_next, rtrial, rem_sub;
  logic                     rge;
  logic [ACC_BITS:0]        err_sum;
  logic [ACC_BITS-1:0]      err_d;
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num;
  logic [LEN_W-1:0]         div_den;
  logic [DIST_BITS-1:0]     div_quot;
  logic                     fpush, fpop;

  pfde_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Operand selection and accumulate action per step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = n_q[i][NORM_W-1] ? (NORM_W-1)'(-n_q[i]) : n_q[i][NORM_W-2:0];
    end
    mul_a    = '0;
    mul_b    = '0;
    op       = OP_ADD;
    shift_sq = 1'b0;
    case (step_q)
      5'd0:  begin mul_a = MA_W'(u_q[1]); mul_b = MB_W'(v_q[2]); op = OP_LOAD; end
      5'd1:  begin mul_a = MA_W'(v_q[1]); mul_b = MB_W'(u_q[2]); op = OP_SUB;  end
      5'd2:  begin mul_a = MA_W'(u_q[2]); mul_b = MB_W'(v_q[0]); op = OP_LOAD; end
      5'd3:  begin mul_a = MA_W'(v_q[2]); mul_b = MB_W'(u_q[0]); op = OP_SUB;  end
      5'd4:  begin mul_a = MA_W'(u_q[0]); mul_b = MB_W'(v_q[1]); op = OP_LOAD; end
      5'd5:  begin mul_a = MA_W'(v_q[0]); mul_b = MB_W'(u_q[1]); op = OP_SUB;  end
      5'd6:  begin mul_a = MA_W'(n_q[0]); mul_b = MB_W'(pt_q.x); op = OP_NEG;  end
      5'd7:  begin mul_a = MA_W'(n_q[1]); mul_b = MB_W'(pt_q.y); op = OP_SUB;  end
      5'd8:  begin mul_a = MA_W'(n_q[2]); mul_b = MB_W'(pt_q.z); op = OP_SUB;  end
      5'd9: begin
        mul_a = MA_W'(nmag[0]); mul_b = MB_W'(nmag[0][NORM_W-2:SQ_SPLIT]);
        op = OP_LOAD; shift_sq = 1'b1;
      end
      5'd10: begin mul_a = MA_W'(nmag[0]); mul_b = MB_W'(nmag[0][SQ_SPLIT-1:0]); end
      5'd11: begin
        mul_a = MA_W'(nmag[1]); mul_b = MB_W'(nmag[1][NORM_W-2:SQ_SPLIT]);
        shift_sq = 1'b1;
      end
      5'd12: begin mul_a = MA_W'(nmag[1]); mul_b = MB_W'(nmag[1][SQ_SPLIT-1:0]); end
      5'd13: begin
        mul_a = MA_W'(nmag[2]); mul_b = MB_W'(nmag[2][NORM_W-2:SQ_SPLIT]);
        shift_sq = 1'b1;
      end
      5'd14: begin mul_a = MA_W'(nmag[2]); mul_b = MB_W'(nmag[2][SQ_SPLIT-1:0]); end
      5'd15: begin mul_a = MA_W'(n_q[0]); mul_b = MB_W'(pt_q.x); op = OP_LOAD; end
      5'd16: begin mul_a = MA_W'(n_q[1]); mul_b = MB_W'(pt_q.y); end
      5'd17: begin mul_a = MA_W'(n_q[2]); mul_b = MB_W'(pt_q.z); op = OP_ADD_OFF; end
      default: ;
    endcase
  end

  always_comb begin
    term = shift_sq ? (SUM_W'(prod_q) <<< SQ_SPLIT) : SUM_W'(prod_q);
    case (op)
      OP_LOAD:    acc_d = term;
      OP_SUB:     acc_d = acc_q - term;
      OP_NEG:     acc_d = -term;
      OP_ADD_OFF: acc_d = acc_q + term + SUM_W'(off_q);
      default:    acc_d = acc_q + term;
    endcase
  end

  assign acc_mag = acc_q[SUM_W-1] ? (MAG_W)'(-acc_q) : acc_q[MAG_W-1:0];

  // Square root: two radicand bits per step
  assign rem_next = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign rtrial   = {root_q, 2'b01};
  assign rge      = rem_next >= rtrial;
  assign rem_sub  = rem_next - rtrial;

  // Running statistics
  always_comb begin
    err_sum = {1'b0, err_q} + (ACC_BITS+1)'(dist_q);
    if (!mode_q) begin
      err_d = (err_sum > {1'b0, ACC_MAX}) ? ACC_MAX : err_sum[ACC_BITS-1:0];
    end else if (cnt_q == '0) begin
      err_d = ACC_BITS'(dist_q);
    end else begin
      err_d = err_sum[ACC_BITS:1];
    end
  end

  assign div_start = (st_q == ST_DIV) ||
                     (st_q == ST_RES && cnt_q != '0 && !mode_q);
  assign div_num   = (st_q == ST_DIV) ? {acc_mag, {FRAC_BITS{1'b0}}} : NUM_W'(err_q);
  assign div_den   = (st_q == ST_DIV) ? len_q : LEN_W'(cnt_q);

  assign cmd_pop_o = (st_q == ST_IDLE) && !emit_q && cmd_valid_i;

  assign empty    = (fcnt_q == 2'd0);
  assign result_o = fifo_q[frd_q];
  assign fpop     = pop && !empty;
  assign fpush    = emit_q && (fcnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      emit_q <= 1'b0;
      step_q <= STEP_FIT_FIRST;
      rcnt_q <= '0;
      mode_q <= 1'b0;
      for (int i = 0; i < 3; i++) n_q[i] <= '0;
      off_q  <= '0;
      len_q  <= '0;
      err_q  <= '0;
      cnt_q  <= '0;
      fwr_q  <= 1'b0;
      frd_q  <= 1'b0;
      fcnt_q <= 2'd0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (fpush) begin
        fwr_q  <= ~fwr_q;
        emit_q <= 1'b0;
        err_q  <= '0;
        cnt_q  <= '0;
      end
      if (fpop) frd_q <= ~frd_q;
      fcnt_q <= fcnt_q + {1'b0, fpush} - {1'b0, fpop};

      case (st_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.kind == CMD_FIT) begin
              step_q <= STEP_FIT_FIRST;
              st_q   <= ST_MUL;
            end else if (!cmd_i.coord_valid) begin
              if (cmd_i.last) st_q <= ST_RES;
            end else if (len_q == '0) begin
              st_q <= ST_UPD;
            end else begin
              step_q <= STEP_SMP_FIRST;
              st_q   <= ST_MUL;
            end
          end
        end
        ST_MUL: st_q <= ST_ACC;
        ST_ACC: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            5'd1: n_q[0] <= acc_d[NORM_W-1:0];
            5'd3: n_q[1] <= acc_d[NORM_W-1:0];
            5'd5: n_q[2] <= acc_d[NORM_W-1:0];
            5'd8: off_q  <= acc_d[OFF_W-1:0];
            default: ;
          endcase
          if (step_q == STEP_SQ_LAST) begin
            rcnt_q <= '0;
            st_q   <= ST_ROOT;
          end else if (step_q == STEP_SMP_LAST) begin
            st_q <= ST_DIV;
          end else begin
            st_q <= ST_MUL;
          end
        end
        ST_ROOT: begin
          rcnt_q <= rcnt_q + 1'b1;
          if (rcnt_q == RCNT_W'(ROOT_STEPS - 1)) begin
            len_q <= {root_q[LEN_W-2:0], rge};
            st_q  <= ST_IDLE;
          end
        end
        ST_DIV: st_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) st_q <= ST_UPD;
        end
        ST_UPD: begin
          err_q <= err_d;
          if (cnt_q != COUNT_MAX) cnt_q <= cnt_q + 1'b1;
          st_q <= last_q ? ST_RES : ST_IDLE;
        end
        ST_RES: begin
          if (cnt_q != '0 && !mode_q) begin
            st_q <= ST_RWAIT;
          end else begin
            emit_q <= 1'b1;
            st_q   <= ST_IDLE;
          end
        end
        ST_RWAIT: begin
          if (div_done) begin
            emit_q <= 1'b1;
            st_q   <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // IDLE waits for a pending result to leave before taking new work
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          last_q <= cmd_i.last;
          dist_q <= '0;
          if (cmd_i.kind == CMD_FIT) begin
            pt_q   <= cmd_i.pa;
            u_q[0] <= DIFF_W'(cmd_i.pb.x) - DIFF_W'(cmd_i.pa.x);
            u_q[1] <= DIFF_W'(cmd_i.pb.y) - DIFF_W'(cmd_i.pa.y);
            u_q[2] <= DIFF_W'(cmd_i.pb.z) - DIFF_W'(cmd_i.pa.z);
            v_q[0] <= DIFF_W'(cmd_i.pc.x) - DIFF_W'(cmd_i.pa.x);
            v_q[1] <= DIFF_W'(cmd_i.pc.y) - DIFF_W'(cmd_i.pa.y);
            v_q[2] <= DIFF_W'(cmd_i.pc.z) - DIFF_W'(cmd_i.pa.z);
          end else begin
            pt_q <= cmd_i.pc;
          end
        end
      end
      ST_MUL: prod_q <= mul_a * mul_b;
      ST_ACC: begin
        acc_q <= acc_d;
        if (step_q == STEP_SQ_LAST) begin
          rad_q  <= acc_d[RAD_W-1:0];
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_ROOT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        rem_q  <= rge ? rem_sub[REM_W-1:0] : rem_next[REM_W-1:0];
        root_q <= {root_q[LEN_W-2:0], rge};
      end
      ST_DWAIT: begin
        if (div_done) dist_q <= div_quot;
      end
      ST_RES: begin
        if (cnt_q == '0) begin
          res_q <= '0;
        end else begin
          res_q <= (err_q > ACC_BITS'(DIST_MAX)) ? DIST_MAX : err_q[DIST_BITS-1:0];
        end
      end
      ST_RWAIT: begin
        if (div_done) res_q <= div_quot;
      end
      default: ;
    endcase
    if (fpush) begin
      fifo_q[fwr_q] <= '{error_distance: res_q, point_count: cnt_q,
                         no_points: (cnt_q == '0), degenerate_plane: (len_q == '0)};
    end
  end

endmodule

[hw/rtl/plane_fit_distance_error_core.sv]
// Top level of the plane fit distance error block.
// Items enter through a queue-style port: an item transfers on a clock edge
// with push high and full low. Reference items (req_type 0) are collected in
// threes; the third fits a plane (cross product, offset, integer square root
// of the squared norm) in steps of the one shared multiplier, each a multiply
// then an accumulate, and one radicand bit pair per cycle in the root loop.
// A valid sample point spends most of its time in the 25-step restoring
// divider by the norm; a sample with last set then adds the mean division
// (in mean mode) and emits one result. Results leave through a
// two-entry queue: result_o is valid while empty is low and transfers on an
// edge with pop high. A short command queue lets the front accept items
// while the engine works; full rises once that queue holds two commands, and
// the engine holds a finished result until the result queue has room.
// Reset clears the reference count, the plane (reported as degenerate), the
// running error and the count; error_mode resets to mean. cfg_we_i writes
// error_mode from cfg_wdata_i; use only while idle, the block does not check.
module plane_fit_distance_error_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pfde_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output pfde_pkg::out_item_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import pfde_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  pfde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pfde_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

[tb/plane_fit_distance_error_core_tb.sv]
// Testbench for the plane fit distance error core: directed table plus random clouds.
`timescale 1ns / 100ps

module plane_fit_distance_error_core_tb;
  import pfde_pkg::*;

  localparam bit MODE_MEAN    = 1'b0;
  localparam bit MODE_RUNNING = 1'b1;
  localparam int HALF_HIGH    = 6;
  localparam int HALF_LOW     = 6;
  localparam int SETTLE_CYC   = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_START   = 10000;
  localparam int HOLD_STOP    = 13000;
  localparam int ITEM_TARGET  = 850;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    in_item_t  it;
    bit        has_res;
    out_item_t res;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;

  plane_fit_distance_error_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #HALF_HIGH clk_i = 1'b1;
    #HALF_LOW  clk_i = 1'b0;
  end

  // plane and cloud state of the predictor
  bit           cur_mode;
  point_t       ref_pts [2];
  int unsigned  ref_cnt;
  wide_t        nrm [3];
  wide_t        plane_off;
  logic [127:0] nrm_len;
  logic [63:0]  err_acc;
  logic [63:0]  pt_cnt;

  out_item_t    pending_q [$];
  int           err_cnt;
  int           items_sent;
  int           cycle_cnt;
  bit           quiet;

  function automatic logic [127:0] int_sqrt(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic void fit_plane(point_t c);
    wide_t ax, ay, az, ux, uy, uz, vx, vy, vz;
    ax = ref_pts[0].x; ay = ref_pts[0].y; az = ref_pts[0].z;
    ux = wide_t'(ref_pts[1].x) - ax;
    uy = wide_t'(ref_pts[1].y) - ay;
    uz = wide_t'(ref_pts[1].z) - az;
    vx = wide_t'(c.x) - ax;
    vy = wide_t'(c.y) - ay;
    vz = wide_t'(c.z) - az;
    nrm[0] = uy * vz - vy * uz;
    nrm[1] = uz * vx - vz * ux;
    nrm[2] = ux * vy - vx * uy;
    plane_off = -(nrm[0] * ax + nrm[1] * ay + nrm[2] * az);
    nrm_len = int_sqrt(nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2]);
  endfunction

  function automatic logic [63:0] plane_dist(in_item_t p);
    wide_t        s;
    logic [127:0] q;
    if (nrm_len == 0) return 0;
    s = nrm[0] * wide_t'(p.x) + nrm[1] * wide_t'(p.y) + nrm[2] * wide_t'(p.z) + plane_off;
    if (s < 0) s = -s;
    s = s <<< FRAC_BITS;
    q = 128'(s) / nrm_len;
    return (q > DIST_MAX) ? 64'(DIST_MAX) : q[63:0];
  endfunction

  // updates the model state; returns 1 and the result when the item closes a cloud
  function automatic bit predict_error(in_item_t it, output out_item_t r);
    logic [63:0] d;
    logic [63:0] v;
    point_t      p;
    r = '0;
    p.x = it.x; p.y = it.y; p.z = it.z;
    if (it.req_type == REQ_REFERENCE) begin
      if (!it.coord_valid) return 0;
      if (ref_cnt < 2) begin
        ref_pts[ref_cnt] = p;
        ref_cnt++;
      end else begin
        fit_plane(p);
        ref_cnt = 0;
      end
      return 0;
    end
    if (it.coord_valid) begin
      d = plane_dist(it);
      if (cur_mode == MODE_MEAN) begin
        err_acc += d;
        if (err_acc > ACC_MAX) err_acc = 64'(ACC_MAX);
      end else if (pt_cnt == 0) begin
        err_acc = d;
      end else begin
        err_acc = (err_acc + d) >> 1;
      end
      if (pt_cnt < COUNT_MAX) pt_cnt++;
    end
    if (!it.last) return 0;
    if (pt_cnt == 0) v = 0;
    else if (cur_mode == MODE_MEAN) v = err_acc / pt_cnt;
    else v = err_acc;
    if (v > DIST_MAX) v = 64'(DIST_MAX);
    r.error_distance   = v[DIST_BITS-1:0];
    r.point_count      = pt_cnt[COUNT_BITS-1:0];
    r.no_points        = (pt_cnt == 0);
    r.degenerate_plane = (nrm_len == 0);
    err_acc = 0;
    pt_cnt  = 0;
    return 1;
  endfunction

  function automatic in_item_t mk_item(bit rt, int x, int y, int z, bit v, bit l);
    in_item_t it;
    it.req_type    = rt ? REQ_SAMPLE : REQ_REFERENCE;
    it.x           = x[COORD_BITS-1:0];
    it.y           = y[COORD_BITS-1:0];
    it.z           = z[COORD_BITS-1:0];
    it.coord_valid = v;
    it.last        = l;
    return it;
  endfunction

  function automatic out_item_t mk_res(int d, int c, bit np, bit dg);
    out_item_t r;
    r.error_distance   = d[DIST_BITS-1:0];
    r.point_count      = c[COUNT_BITS-1:0];
    r.no_points        = np;
    r.degenerate_plane = dg;
    return r;
  endfunction

  function automatic int rnd_coord();
    if ($urandom_range(99) < 50) return $signed(16'($urandom()));
    return int'($urandom_range(200)) - 100;
  endfunction

  // drive one item until it transfers; a fixed expectation overrides the model
  task automatic send_item(in_item_t it, bit has_res = 0, out_item_t fixed = '0);
    out_item_t r;
    while (!quiet && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (predict_error(it, r)) pending_q.push_back(has_res ? fixed : r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode = m;
  endtask

  task automatic run_cloud();
    int n;
    int s;
    if ($urandom_range(99) < 10) begin
      // noise: fully random items
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_item(mk_item($urandom_range(1), rnd_coord(), rnd_coord(), rnd_coord(),
                          $urandom_range(1), $urandom_range(1)));
      return;
    end
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(99) < 15) begin
        s = rnd_coord();
        for (int i = 1; i <= 3; i++)
          send_item(mk_item(0, s * i / 4, s * i / 2, s * i / 4, 1, 0));
      end else begin
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(99) < 8)
            send_item(mk_item(0, rnd_coord(), rnd_coord(), rnd_coord(), 0,
                              $urandom_range(1)));
          send_item(mk_item(0, rnd_coord(), rnd_coord(), rnd_coord(), 1,
                            $urandom_range(1)));
        end
      end
    end
    n = $urandom_range(0, 7);
    for (int i = 0; i <= n; i++)
      send_item(mk_item(1, rnd_coord(), rnd_coord(), rnd_coord(),
                        $urandom_range(99) >= 10, i == n));
  endtask

  // result side: random stalls plus one long hold-off window
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_STOP)
      pop <= 1'b0;
    else
      pop <= quiet || ($urandom_range(99) >= 26);
    if (pop && !empty) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %p", result_o);
      end else begin
        if (result_o.error_distance != pending_q[0].error_distance ||
            result_o.point_count != pending_q[0].point_count ||
            result_o.no_points != pending_q[0].no_points ||
            result_o.degenerate_plane != pending_q[0].degenerate_plane) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp dist=%0d cnt=%0d np=%0b dg=%0b act dist=%0d cnt=%0d np=%0b dg=%0b",
                     pending_q[0].error_distance, pending_q[0].point_count,
                     pending_q[0].no_points, pending_q[0].degenerate_plane,
                     result_o.error_distance, result_o.point_count,
                     result_o.no_points, result_o.degenerate_plane);
        end
        void'(pending_q.pop_front());
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    int   phase;
    cycle_cnt  = 0;
    err_cnt    = 0;
    items_sent = 0;
    quiet      = 1'b0;
    cur_mode   = MODE_MEAN;
    ref_cnt    = 0;
    nrm[0] = 0; nrm[1] = 0; nrm[2] = 0;
    plane_off = 0;
    nrm_len   = 0;
    err_acc   = 0;
    pt_cnt    = 0;

    // directed: degenerate before any plane, empty cloud, ignored references,
    // unit plane, extremes, collinear references
    rw.has_res = 1;
    rw.it = mk_item(1, 0, 0, 0, 1, 1); rw.res = mk_res(0, 1, 0, 1); rows.push_back(rw);
    rw.it = mk_item(1, 0, 0, 0, 0, 1); rw.res = mk_res(0, 0, 1, 1); rows.push_back(rw);
    rw.has_res = 0;
    rw.it = mk_item(0, 5, 5, 5, 0, 0); rows.push_back(rw);
    rw.it = mk_item(0, 0, 0, 0, 1, 1); rows.push_back(rw);
    rw.it = mk_item(0, 1, 0, 0, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, 0, 1, 0, 1, 0); rows.push_back(rw);
    rw.has_res = 1;
    rw.it = mk_item(1, 7, -3, 5, 1, 1); rw.res = mk_res(1280, 1, 0, 0); rows.push_back(rw);
    rw.has_res = 0;
    rw.it = mk_item(1, 0, 0, -32768, 1, 0); rows.push_back(rw);
    rw.it = mk_item(1, 0, 0, 32767, 0, 0); rows.push_back(rw);
    rw.has_res = 1;
    rw.it = mk_item(1, 0, 0, 32767, 1, 1); rw.res = mk_res(8388480, 2, 0, 0); rows.push_back(rw);
    rw.has_res = 0;
    rw.it = mk_item(0, -32768, -32768, -32768, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, 32767, -32768, -32768, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, -32768, 32767, 32767, 1, 0); rows.push_back(rw);
    rw.it = mk_item(1, 32767, 32767, -32768, 1, 0); rows.push_back(rw);
    rw.it = mk_item(1, -32768, -32768, 32767, 1, 1); rows.push_back(rw);
    rw.it = mk_item(0, 1, 1, 1, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, 2, 2, 2, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, 3, 3, 3, 1, 0); rows.push_back(rw);
    rw.has_res = 1;
    rw.it = mk_item(1, 100, -100, 7, 1, 1); rw.res = mk_res(0, 1, 0, 1); rows.push_back(rw);
    rw.has_res = 0;
    rw.it = mk_item(0, -32768, 32767, -32768, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, 32767, 32767, 32767, 1, 0); rows.push_back(rw);
    rw.it = mk_item(0, -32768, -32768, 32767, 1, 0); rows.push_back(rw);
    rw.it = mk_item(1, 32767, -32768, -32768, 1, 0); rows.push_back(rw);
    rw.it = mk_item(1, -1, 0, 1, 1, 1); rows.push_back(rw);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].it, rows[i].has_res, rows[i].res);
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_mode(phase % 2 == 0 ? MODE_RUNNING : MODE_MEAN);
      quiet = (phase == 2);
      for (int k = 0; k < 25 && items_sent < ITEM_TARGET; k++) run_cloud();
      // sender waits for every result before the next setting
      drain();
      phase++;
    end
    quiet = 1'b0;
    drain();

    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
